>>> rtl/pn2d_pkg.sv
// Shared types and fixed-point widths of the 2-D gradient noise block.
package pn2d_pkg;

  localparam int PERM_W  = 8;   // permutation entry width
  localparam int GRAD_W  = 16;  // gradient component, signed Q3.12
  localparam int COORD_W = 32;  // coordinate, signed Q15.16
  localparam int FRAC_W  = 16;  // fraction bits of coordinates and of the datapath
  localparam int GFRAC_W = 12;  // fraction bits of gradient components
  localparam int T_W     = FRAC_W + 1;  // signed fraction in (-1, 1)
  localparam int OFS_W   = FRAC_W + 2;  // corner offset in (-2, 1)
  localparam int U_W     = 23;  // faded weight
  localparam int DOT_W   = 24;  // corner dot product
  localparam int N1_W    = 30;  // first lerp result
  localparam int N_W     = 40;  // final blend
  localparam int OUT_W   = 32;  // saturated result

  typedef enum logic [1:0] {
    OP_WR_PERM = 2'd0,
    OP_WR_GRAD = 2'd1,
    OP_EVAL    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    logic valid;
    logic is_noise;
  } beat_ctl_t;

endpackage

>>> rtl/pn2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pn2d_fade.sv
// Four-stage quintic fade t^3*(t*(6t-15)+10) in Q.16.
module pn2d_fade (
  input  logic                           clk,
  input  logic signed [pn2d_pkg::T_W-1:0] t,
  output logic signed [pn2d_pkg::U_W-1:0] u_r
);
  import pn2d_pkg::*;

  logic signed [23:0] a;
  logic signed [40:0] m1_r;
  logic signed [33:0] m2_r;
  logic signed [T_W-1:0] t_b_r;
  logic signed [23:0] b_nxt;
  logic signed [23:0] b_r;
  logic signed [18:0] t2;
  logic signed [35:0] m3_r;
  logic signed [18:0] t3;
  logic signed [42:0] m4_r;

  assign a = (24'(t) <<< 2) + (24'(t) <<< 1) - 24'sd983040;

  always_ff @(posedge clk) begin
    m1_r  <= 41'(t) * 41'(a);
    m2_r  <= 34'(t) * 34'(t);
    t_b_r <= t;
  end

  assign b_nxt = 24'((m1_r + 41'sd32768) >>> FRAC_W) + 24'sd655360;
  assign t2    = 19'((m2_r + 34'sd32768) >>> FRAC_W);

  always_ff @(posedge clk) begin
    b_r   <= b_nxt;
    m3_r  <= 36'(t2) * 36'(t_b_r);
  end

  assign t3 = 19'((m3_r + 36'sd32768) >>> FRAC_W);

  always_ff @(posedge clk) begin
    m4_r <= 43'(t3) * 43'(b_r);
  end

  always_ff @(posedge clk) begin
    u_r <= U_W'((m4_r + 43'sd32768) >>> FRAC_W);
  end

endmodule

>>> rtl/pn2d_blend.sv
// Bilinear blend of the corner dots, (n+1)/2 mapping and saturation.
module pn2d_blend (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pn2d_pkg::beat_ctl_t               ctl,
  input  logic signed [pn2d_pkg::DOT_W-1:0] d1,
  input  logic signed [pn2d_pkg::DOT_W-1:0] d2,
  input  logic signed [pn2d_pkg::DOT_W-1:0] d3,
  input  logic signed [pn2d_pkg::DOT_W-1:0] d4,
  input  logic signed [pn2d_pkg::U_W-1:0]   u,
  input  logic signed [pn2d_pkg::U_W-1:0]   v,
  output logic                              out_valid_r,
  output logic                              out_is_noise_r,
  output logic signed [pn2d_pkg::OUT_W-1:0] out_value_r
);
  import pn2d_pkg::*;

  beat_ctl_t ctl6_r, ctl7_r, ctl8_r;
  logic signed [DOT_W:0]   diff12, diff34;
  logic signed [47:0]      pa_r, pb_r;
  logic signed [DOT_W-1:0] d1_r, d3_r;
  logic signed [U_W-1:0]   v6_r, v7_r;
  logic signed [N1_W-1:0]  n1_nxt, n2_nxt, n1_r, n2_r, n1_8_r;
  logic signed [N1_W:0]    dn;
  logic signed [53:0]      pn_r;
  logic signed [N_W-1:0]   n, r;

  assign diff12 = (DOT_W+1)'(d2) - (DOT_W+1)'(d1);
  assign diff34 = (DOT_W+1)'(d4) - (DOT_W+1)'(d3);

  always_ff @(posedge clk) begin
    pa_r <= 48'(u) * 48'(diff12);
    pb_r <= 48'(u) * 48'(diff34);
    d1_r <= d1;
    d3_r <= d3;
    v6_r <= v;
  end

  assign n1_nxt = N1_W'(d1_r) + N1_W'((pa_r + 48'sd32768) >>> FRAC_W);
  assign n2_nxt = N1_W'(d3_r) + N1_W'((pb_r + 48'sd32768) >>> FRAC_W);

  always_ff @(posedge clk) begin
    n1_r <= n1_nxt;
    n2_r <= n2_nxt;
    v7_r <= v6_r;
  end

  assign dn = (N1_W+1)'(n2_r) - (N1_W+1)'(n1_r);

  always_ff @(posedge clk) begin
    pn_r   <= 54'(v7_r) * 54'(dn);
    n1_8_r <= n1_r;
  end

  // add one, halve with round half up
  assign n = N_W'(n1_8_r) + N_W'((pn_r + 54'sd32768) >>> FRAC_W);
  assign r = (n + N_W'(65537)) >>> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl6_r <= '0;
      ctl7_r <= '0;
      ctl8_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl6_r <= ctl;
      ctl7_r <= ctl6_r;
      ctl8_r <= ctl7_r;
      out_valid_r <= ctl8_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_is_noise_r <= ctl8_r.is_noise;
    if (!ctl8_r.is_noise) begin
      out_value_r <= '0;
    end else if (r > N_W'(64'sd2147483647)) begin
      out_value_r <= 32'sh7fffffff;
    end else if (r < -N_W'(64'sd2147483648)) begin
      out_value_r <= 32'sh80000000;
    end else begin
      out_value_r <= OUT_W'(r);
    end
  end

endmodule

>>> rtl/perlin_noise_2d.sv
// Top level of the 2-D gradient noise block: table memories and lookup pipeline.
//
// One command channel: an item is taken at a rising edge with start high and
// busy low. busy never rises, so a new item can be taken in every cycle.
// opcode 0 writes a permutation entry, 1 writes a gradient entry, 2 evaluates
// the noise at (in_coord_x, in_coord_y), 3 does nothing. Every item gives one
// result beat, in order: out_valid is high for one cycle at the end of the
// blend pipeline, together with out_is_noise and out_noise_value.
// Writes give an acknowledge beat with out_is_noise low and a zero value.
// Throughput is one item per cycle. Each table copy is accessed at exactly one
// pipeline stage (two permutation copies for the cell lookup, four for the
// corner hashes, four gradient copies), so writes and reads keep item order.
// Tables must be loaded before an evaluation reads them; reset clears only
// the pipeline valid and control bits. The receiver cannot stall the result beats.
module perlin_noise_2d #(
  parameter int TABLE_SIZE = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_opcode,
  input  logic [7:0]                        in_table_index,
  input  logic [pn2d_pkg::PERM_W-1:0]       in_perm_value,
  input  logic signed [pn2d_pkg::GRAD_W-1:0] in_grad_x_value,
  input  logic signed [pn2d_pkg::GRAD_W-1:0] in_grad_y_value,
  input  logic signed [pn2d_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [pn2d_pkg::COORD_W-1:0] in_coord_y,
  output logic                              out_valid,
  output logic                              out_is_noise,
  output logic signed [pn2d_pkg::OUT_W-1:0] out_noise_value
);
  import pn2d_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int GW2   = 2 * GRAD_W;
  localparam logic signed [OFS_W-1:0] ONE = OFS_W'(1 << FRAC_W);

  logic accept;
  op_t  op_in;

  // cell and fraction of the incoming point
  logic [COORD_W-1:0] cell_x, cell_y;
  logic signed [T_W-1:0] fx0, fy0;
  logic [IDX_W-1:0] ix0, ix1, iy0, idx0;

  // stage 1
  logic             v1_r;
  op_t              op1_r;
  logic [IDX_W-1:0] idx1_r, iy1_r;
  logic [PERM_W-1:0] pv1_r;
  logic signed [GRAD_W-1:0] gx1_r, gy1_r;
  logic signed [T_W-1:0] fx1_r, fy1_r;
  logic [PERM_W-1:0] p0, p1;
  logic [IDX_W-1:0] h00, h10, h01, h11;

  // stage 2
  logic             v2_r;
  op_t              op2_r;
  logic [IDX_W-1:0] idx2_r;
  logic signed [GRAD_W-1:0] gx2_r, gy2_r;
  logic signed [T_W-1:0] fx2_r, fy2_r;
  logic [PERM_W-1:0] hd [4];

  // stage 3
  logic  v3_r;
  op_t   op3_r;
  logic signed [T_W-1:0] fx3_r, fy3_r;
  logic [GW2-1:0] gd [4];
  logic signed [OFS_W-1:0] ox [4];
  logic signed [OFS_W-1:0] oy [4];

  // stage 4
  logic  v4_r;
  op_t   op4_r;
  logic signed [33:0] px_r [4];
  logic signed [33:0] py_r [4];

  // stage 5
  beat_ctl_t ctl5_r;
  logic signed [DOT_W-1:0] d_r [4];
  logic signed [U_W-1:0] u, v;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op_in  = op_t'(in_opcode);

  // truncate toward zero: floor, plus one for a negative value with fraction bits
  assign cell_x = COORD_W'(in_coord_x >>> FRAC_W)
                + COORD_W'(in_coord_x[COORD_W-1] && (in_coord_x[FRAC_W-1:0] != '0));
  assign cell_y = COORD_W'(in_coord_y >>> FRAC_W)
                + COORD_W'(in_coord_y[COORD_W-1] && (in_coord_y[FRAC_W-1:0] != '0));
  assign fx0 = {in_coord_x[COORD_W-1] && (in_coord_x[FRAC_W-1:0] != '0),
                in_coord_x[FRAC_W-1:0]};
  assign fy0 = {in_coord_y[COORD_W-1] && (in_coord_y[FRAC_W-1:0] != '0),
                in_coord_y[FRAC_W-1:0]};
  assign ix0  = cell_x[IDX_W-1:0];
  assign ix1  = ix0 + IDX_W'(1);
  assign iy0  = cell_y[IDX_W-1:0];
  assign idx0 = IDX_W'(in_table_index);

  pn2d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_a0 (
    .clk, .we(accept && (op_in == OP_WR_PERM)), .waddr(idx0), .wdata(in_perm_value),
    .raddr(ix0), .rdata(p0)
  );
  pn2d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_a1 (
    .clk, .we(accept && (op_in == OP_WR_PERM)), .waddr(idx0), .wdata(in_perm_value),
    .raddr(ix1), .rdata(p1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ctl5_r <= '0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      ctl5_r <= '{valid: v4_r, is_noise: (op4_r == OP_EVAL)};
    end
  end

  always_ff @(posedge clk) begin
    op1_r  <= op_in;
    idx1_r <= idx0;
    iy1_r  <= iy0;
    pv1_r  <= in_perm_value;
    gx1_r  <= in_grad_x_value;
    gy1_r  <= in_grad_y_value;
    fx1_r  <= fx0;
    fy1_r  <= fy0;
  end

  // corner hashes, wrapped to the table size
  assign h00 = IDX_W'(p0) + iy1_r;
  assign h10 = IDX_W'(p1) + iy1_r;
  assign h01 = IDX_W'(p0) + iy1_r + IDX_W'(1);
  assign h11 = IDX_W'(p1) + iy1_r + IDX_W'(1);

  pn2d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_b0 (
    .clk, .we(v1_r && (op1_r == OP_WR_PERM)), .waddr(idx1_r), .wdata(pv1_r),
    .raddr(h00), .rdata(hd[0])
  );
  pn2d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_b1 (
    .clk, .we(v1_r && (op1_r == OP_WR_PERM)), .waddr(idx1_r), .wdata(pv1_r),
    .raddr(h10), .rdata(hd[1])
  );
  pn2d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_b2 (
    .clk, .we(v1_r && (op1_r == OP_WR_PERM)), .waddr(idx1_r), .wdata(pv1_r),
    .raddr(h01), .rdata(hd[2])
  );
  pn2d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_b3 (
    .clk, .we(v1_r && (op1_r == OP_WR_PERM)), .waddr(idx1_r), .wdata(pv1_r),
    .raddr(h11), .rdata(hd[3])
  );

  pn2d_fade u_fade_x (.clk, .t(fx1_r), .u_r(u));
  pn2d_fade u_fade_y (.clk, .t(fy1_r), .u_r(v));

  always_ff @(posedge clk) begin
    op2_r  <= op1_r;
    idx2_r <= idx1_r;
    gx2_r  <= gx1_r;
    gy2_r  <= gy1_r;
    fx2_r  <= fx1_r;
    fy2_r  <= fy1_r;
  end

  for (genvar g = 0; g < 4; g++) begin : g_grad
    pn2d_ram #(.WIDTH(GW2), .DEPTH(TABLE_SIZE)) u_grad (
      .clk, .we(v2_r && (op2_r == OP_WR_GRAD)), .waddr(idx2_r), .wdata({gx2_r, gy2_r}),
      .raddr(IDX_W'(hd[g])), .rdata(gd[g])
    );
  end

  always_ff @(posedge clk) begin
    op3_r <= op2_r;
    fx3_r <= fx2_r;
    fy3_r <= fy2_r;
  end

  // corner order: (0,0), (1,0), (0,1), (1,1)
  assign ox[0] = OFS_W'(fx3_r);
  assign ox[1] = OFS_W'(fx3_r) - ONE;
  assign ox[2] = OFS_W'(fx3_r);
  assign ox[3] = OFS_W'(fx3_r) - ONE;
  assign oy[0] = OFS_W'(fy3_r);
  assign oy[1] = OFS_W'(fy3_r);
  assign oy[2] = OFS_W'(fy3_r) - ONE;
  assign oy[3] = OFS_W'(fy3_r) - ONE;

  always_ff @(posedge clk) begin
    op4_r <= op3_r;
    for (int k = 0; k < 4; k++) begin
      px_r[k] <= 34'($signed(gd[k][GW2-1:GRAD_W])) * 34'(ox[k]);
      py_r[k] <= 34'($signed(gd[k][GRAD_W-1:0])) * 34'(oy[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      d_r[k] <= DOT_W'((35'(px_r[k]) + 35'(py_r[k]) + 35'sd2048) >>> GFRAC_W);
    end
  end

  pn2d_blend u_blend (
    .clk, .rst_n,
    .ctl(ctl5_r),
    .d1(d_r[0]), .d2(d_r[1]), .d3(d_r[2]), .d4(d_r[3]),
    .u, .v,
    .out_valid_r(out_valid),
    .out_is_noise_r(out_is_noise),
    .out_value_r(out_noise_value)
  );

endmodule
